@@ rtl/core/crld_pkg.sv @@
// ----------------------------------------------------------------------------
// crld_pkg
// Types, register indexes and helper functions for the coefficient decoder.
// ----------------------------------------------------------------------------
package crld_pkg;

   localparam int unsigned CSR_DATA_W  = 5;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned COEF_LAST   = 63;
   localparam int unsigned ZRL_SKIP    = 16;
   localparam int unsigned BLOCK_SIZE  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LUMA_BLOCKS = 2'd0,
      CSR_CB_BLOCKS   = 2'd1,
      CSR_CR_BLOCKS   = 2'd2,
      CSR_COLOUR_MODE = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      COMP_LUMA = 2'd0,
      COMP_CB   = 2'd1,
      COMP_CR   = 2'd2
   } comp_type;

   typedef struct packed {
      logic [7:0]  symbol;
      logic [14:0] extra_bits;
   } req_word_type;

   typedef struct packed {
      logic [5:0]         coef_index;
      logic signed [15:0] coef_value;
      logic               coef_write;
      logic [5:0]         block_number;
      logic [1:0]         component;
      logic               block_done;
      logic               mcu_done;
      logic               position_overflow;
      logic               next_is_dc;
      logic [1:0]         next_component;
   } rsp_word_type;

   function automatic logic [4:0] clamp_count(input logic [4:0] n, input logic [4:0] max_n);
      logic [4:0] r;
      r = n;
      if (n == 5'd0) begin
         r = 5'd1;
      end else if (n > max_n) begin
         r = max_n;
      end
      return r;
   endfunction

   function automatic logic [15:0] class_value(input logic [3:0] s, input logic [14:0] bits);
      logic [15:0] mask;
      logic [15:0] v;
      logic [15:0] r;
      mask = (16'd1 << s) - 16'd1;
      v    = {1'b0, bits} & mask;
      if (s == 4'd0) begin
         r = 16'd0;
      end else if (v[s - 4'd1]) begin
         r = v;
      end else begin
         r = v - mask;
      end
      return r;
   endfunction

endpackage

@@ rtl/core/crld_if.sv @@
// ----------------------------------------------------------------------------
// crld_req_if / crld_rsp_if
// Valid/ready channels for symbol words in and coefficient words out.
// ----------------------------------------------------------------------------
interface crld_req_if import crld_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface crld_rsp_if import crld_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/jpeg_coefficient_run_length_decoder.sv @@
// ----------------------------------------------------------------------------
// jpeg_coefficient_run_length_decoder
// Baseline DC/AC coefficient decode: DC prediction, run/size expansion,
// block and MCU tracking.
//
//   channel  dir  contents
//   req_ch   in   symbol, extra_bits
//   rsp_ch   out  coefficient index/value, block and MCU status, next table
//   csr_*    in   luma/Cb/Cr block counts, colour mode
//
// One word accepted per cycle while the result register is free or being taken;
// each yields one result word, registered and offered in the next cycle. The DC add
// and the position increment sit between state and the result register. Reset clears
// predictors and position, expects DC of block 0. A full result register not taken
// stalls req_ch; taking it frees the slot in the same cycle.
// ----------------------------------------------------------------------------
module jpeg_coefficient_run_length_decoder import crld_pkg::*; #(
   parameter int unsigned MAX_BLOCKS_PER_COMPONENT = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   crld_req_if.sink               req_ch,
   crld_rsp_if.source             rsp_ch,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam logic [4:0] MAX_CNT = 5'(MAX_BLOCKS_PER_COMPONENT);

   logic [4:0]   luma_blocks_ff;
   logic [4:0]   cb_blocks_ff;
   logic [4:0]   cr_blocks_ff;
   logic         colour_mode_ff;

   logic [15:0]  dc_pred_ff [3];
   logic [15:0]  dc_pred_in;
   logic [5:0]   coef_position_ff;
   logic [5:0]   coef_position_in;
   logic         expect_dc_ff;
   logic         expect_dc_in;
   logic [5:0]   block_in_mcu_ff;
   logic [5:0]   block_in_mcu_in;

   rsp_word_type rsp_ff;
   rsp_word_type rsp_in;
   logic         rsp_valid_ff;

   logic         req_fire;
   logic [4:0]   luma_cnt;
   logic [4:0]   cb_cnt;
   logic [4:0]   cr_cnt;
   logic [5:0]   total_blocks;
   logic [1:0]   comp;
   logic [3:0]   dc_class;
   logic [3:0]   run;
   logic [3:0]   size;
   logic [6:0]   new_pos;
   logic         done;
   logic [6:0]   blk_inc;

   function automatic logic [1:0] comp_of(input logic [5:0] b, input logic colour,
                                          input logic [4:0] l, input logic [4:0] c);
      logic [1:0] r;
      if (!colour || (b < {1'b0, l})) begin
         r = COMP_LUMA;
      end else if (b < ({1'b0, l} + {1'b0, c})) begin
         r = COMP_CB;
      end else begin
         r = COMP_CR;
      end
      return r;
   endfunction

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   assign luma_cnt     = clamp_count(luma_blocks_ff, MAX_CNT);
   assign cb_cnt       = clamp_count(cb_blocks_ff, MAX_CNT);
   assign cr_cnt       = clamp_count(cr_blocks_ff, MAX_CNT);
   assign total_blocks = colour_mode_ff ? ({1'b0, luma_cnt} + {1'b0, cb_cnt} + {1'b0, cr_cnt})
                                        : {1'b0, luma_cnt};

   assign comp     = comp_of(block_in_mcu_ff, colour_mode_ff, luma_cnt, cb_cnt);
   assign dc_class = (|req_ch.payload.symbol[7:4]) ? 4'hF : req_ch.payload.symbol[3:0];
   assign run      = req_ch.payload.symbol[7:4];
   assign size     = req_ch.payload.symbol[3:0];
   assign new_pos  = {1'b0, coef_position_ff} + {3'd0, run} + 7'd1;
   assign blk_inc  = {1'b0, block_in_mcu_ff} + 7'd1;

   always_comb begin
      rsp_in           = '0;
      dc_pred_in       = dc_pred_ff[comp] + class_value(dc_class, req_ch.payload.extra_bits);
      coef_position_in = coef_position_ff;
      expect_dc_in     = expect_dc_ff;
      block_in_mcu_in  = block_in_mcu_ff;
      done             = 1'b0;

      rsp_in.block_number = block_in_mcu_ff;
      rsp_in.component    = comp;

      if (expect_dc_ff) begin
         rsp_in.coef_write = 1'b1;
         rsp_in.coef_value = dc_pred_in;
         coef_position_in  = '0;
         expect_dc_in      = 1'b0;
      end else if ((size == 4'd0) && (run == 4'd0)) begin
         done = 1'b1;
      end else if (new_pos > 7'(COEF_LAST)) begin
         rsp_in.position_overflow = 1'b1;
         done                     = 1'b1;
      end else begin
         coef_position_in = new_pos[5:0];
         if (size != 4'd0) begin
            rsp_in.coef_write = 1'b1;
            rsp_in.coef_index = new_pos[5:0];
            rsp_in.coef_value = class_value(size, req_ch.payload.extra_bits);
            done              = (new_pos == 7'(COEF_LAST));
         end
      end

      if (done) begin
         coef_position_in = '0;
         expect_dc_in     = 1'b1;
         if (blk_inc >= {1'b0, total_blocks}) begin
            rsp_in.mcu_done = 1'b1;
            block_in_mcu_in = '0;
         end else begin
            block_in_mcu_in = blk_inc[5:0];
         end
      end

      rsp_in.block_done     = done;
      rsp_in.next_is_dc     = expect_dc_in;
      rsp_in.next_component = comp_of(block_in_mcu_in, colour_mode_ff, luma_cnt, cb_cnt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_blocks_ff   <= 5'd1;
         cb_blocks_ff     <= 5'd1;
         cr_blocks_ff     <= 5'd1;
         colour_mode_ff   <= 1'b0;
         dc_pred_ff[0]    <= '0;
         dc_pred_ff[1]    <= '0;
         dc_pred_ff[2]    <= '0;
         coef_position_ff <= '0;
         expect_dc_ff     <= 1'b1;
         block_in_mcu_ff  <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_LUMA_BLOCKS: luma_blocks_ff <= csr_data;
               CSR_CB_BLOCKS:   cb_blocks_ff   <= csr_data;
               CSR_CR_BLOCKS:   cr_blocks_ff   <= csr_data;
               CSR_COLOUR_MODE: colour_mode_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (req_fire) begin
            if (expect_dc_ff) begin
               dc_pred_ff[comp] <= dc_pred_in;
            end
            coef_position_ff <= coef_position_in;
            expect_dc_ff     <= expect_dc_in;
            block_in_mcu_ff  <= block_in_mcu_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   a_dc_then_ac: assert property (@(posedge clock) disable iff (reset)
      req_fire && expect_dc_ff |=> !expect_dc_ff)
      else $error("DC word did not move to AC phase");

   a_dc_at_zero: assert property (@(posedge clock) disable iff (reset)
      expect_dc_ff |-> coef_position_ff == '0)
      else $error("position not cleared while expecting DC");

   a_mcu_wrap: assert property (@(posedge clock) disable iff (reset)
      req_fire && rsp_in.mcu_done |=> block_in_mcu_ff == '0 && expect_dc_ff)
      else $error("block counter not wrapped at end of MCU");

   a_ovf_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.position_overflow |-> !rsp_ff.coef_write && rsp_ff.block_done)
      else $error("overflow word carries a write or leaves block open");

   a_done_next_dc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.block_done |-> rsp_ff.next_is_dc)
      else $error("block end without DC expectation");

endmodule

@@ verif/tb_jpeg_coefficient_run_length_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_jpeg_coefficient_run_length_decoder
// Self-checking bench for the baseline DC/AC coefficient decoder. Symbol
// words go in on the request channel. A behavioral decoder inside the bench
// tracks DC predictors, zigzag position and block/MCU progress, and builds
// the expected coefficient word for each accepted symbol. Each returned word
// is then checked field by field. Directed symbols cover the corner cases.
// Then a sweep of MCU layouts, reconfiguration in the middle of an MCU,
// output back-pressure, a drained pause and a long random stream run under
// random idling on both channels; idling stops for the last part of the stream.
// ----------------------------------------------------------------------------
module tb_jpeg_coefficient_run_length_decoder;
   import crld_pkg::*;

   localparam int unsigned MAX_BLOCKS  = 16;
   localparam logic [7:0]  SYM_EOB     = 8'h00;
   localparam logic [7:0]  SYM_ZRL     = 8'hF0;
   localparam int          QUIET_LIMIT = 5000;
   localparam int          HOLD_CYCLES = 300;
   localparam int          ITEM_TARGET = 2000;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   crld_req_if req_ch ();
   crld_rsp_if rsp_ch ();

   jpeg_coefficient_run_length_decoder #(
      .MAX_BLOCKS_PER_COMPONENT(MAX_BLOCKS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   logic [4:0]  luma_cfg   = 5'd1;
   logic [4:0]  cb_cfg     = 5'd1;
   logic [4:0]  cr_cfg     = 5'd1;
   bit          colour_cfg = 1'b0;
   logic [15:0] dc_base [3] = '{default: 16'd0};
   int          coef_pos    = 0;
   bit          awaiting_dc = 1'b1;
   int          mcu_block   = 0;

   rsp_word_type pending_coefs [$];
   int mismatches      = 0;
   int items_sent      = 0;
   int quiet_cycles    = 0;
   int receiver_hold   = 0;
   int stall_left      = 0;
   bit sender_idling   = 1'b0;
   bit receiver_idling = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int effective_count(logic [4:0] n);
      if (n == 5'd0) return 1;
      if (n > MAX_BLOCKS) return MAX_BLOCKS;
      return int'(n);
   endfunction

   function automatic int blocks_per_mcu();
      int t;
      t = effective_count(luma_cfg);
      if (colour_cfg) t += effective_count(cb_cfg) + effective_count(cr_cfg);
      return t;
   endfunction

   function automatic comp_type block_component(int b);
      int l;
      int c;
      l = effective_count(luma_cfg);
      c = effective_count(cb_cfg);
      if (!colour_cfg || b < l) return COMP_LUMA;
      if (b < l + c) return COMP_CB;
      return COMP_CR;
   endfunction

   function automatic logic [15:0] magnitude_to_value(logic [3:0] size, logic [14:0] bits);
      logic [15:0] mask;
      logic [15:0] v;
      if (size == 4'd0) return 16'd0;
      mask = (16'd1 << size) - 16'd1;
      v    = {1'b0, bits} & mask;
      if (v[int'(size) - 1]) return v;
      return v - mask;
   endfunction

   function automatic rsp_word_type decode_symbol(req_word_type w);
      rsp_word_type r;
      comp_type     comp;
      int           blk;
      int           np;
      logic [3:0]   cls;
      logic [3:0]   run;
      logic [3:0]   size;
      logic [15:0]  sum;
      bit           ended;
      r     = '0;
      ended = 1'b0;
      blk   = mcu_block;
      comp  = block_component(blk);
      r.block_number = blk[5:0];
      r.component    = comp;
      if (awaiting_dc) begin
         cls  = (w.symbol > 8'd15) ? 4'd15 : w.symbol[3:0];
         sum  = dc_base[comp] + magnitude_to_value(cls, w.extra_bits);
         dc_base[comp] = sum;
         r.coef_write  = 1'b1;
         r.coef_value  = sum;
         coef_pos      = 0;
         awaiting_dc   = 1'b0;
      end else begin
         run  = w.symbol[7:4];
         size = w.symbol[3:0];
         if (w.symbol == SYM_EOB) begin
            ended = 1'b1;
         end else begin
            np = coef_pos + int'(run) + 1;
            if (np > COEF_LAST) begin
               r.position_overflow = 1'b1;
               ended = 1'b1;
            end else begin
               coef_pos = np;
               if (size != 4'd0) begin
                  r.coef_write = 1'b1;
                  r.coef_index = np[5:0];
                  r.coef_value = magnitude_to_value(size, w.extra_bits);
                  if (np == COEF_LAST) ended = 1'b1;
               end
            end
         end
      end
      if (ended) begin
         r.block_done = 1'b1;
         coef_pos     = 0;
         awaiting_dc  = 1'b1;
         if (blk + 1 >= blocks_per_mcu()) begin
            r.mcu_done = 1'b1;
            mcu_block  = 0;
         end else begin
            mcu_block = blk + 1;
         end
      end
      r.next_is_dc     = awaiting_dc;
      r.next_component = block_component(mcu_block);
      return r;
   endfunction

   task automatic check_field(string field, int want, int got);
      if (want != got) begin
         $display("%0t %s expected %0d actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (pending_coefs.size() == 0) begin
               $display("%0t unexpected word expected none actual %h", $time, got);
               mismatches++;
            end else begin
               want = pending_coefs.pop_front();
               check_field("coef_index", int'(want.coef_index), int'(got.coef_index));
               check_field("coef_value", int'(want.coef_value), int'(got.coef_value));
               check_field("coef_write", int'(want.coef_write), int'(got.coef_write));
               check_field("block_number", int'(want.block_number),
                           int'(got.block_number));
               check_field("component", int'(want.component), int'(got.component));
               check_field("block_done", int'(want.block_done), int'(got.block_done));
               check_field("mcu_done", int'(want.mcu_done), int'(got.mcu_done));
               check_field("position_overflow", int'(want.position_overflow),
                           int'(got.position_overflow));
               check_field("next_is_dc", int'(want.next_is_dc), int'(got.next_is_dc));
               check_field("next_component", int'(want.next_component),
                           int'(got.next_component));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_coefs.push_back(decode_symbol(req_ch.payload));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_jpeg_coefficient_run_length_decoder: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (receiver_hold > 0) begin
            receiver_hold--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_symbol(logic [7:0] sym, logic [14:0] bits);
      int gap;
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= {sym, bits};
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      items_sent++;
   endtask

   task automatic wait_for_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_coefs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= val;
      @(posedge clock);
   endtask

   task automatic apply_setting(logic [4:0] luma, logic [4:0] cb, logic [4:0] cr, bit mode);
      logic [3:0] pad;
      pad = 4'($urandom_range(0, 15));
      wait_for_idle();
      write_register(CSR_LUMA_BLOCKS, luma);
      write_register(CSR_CB_BLOCKS, cb);
      write_register(CSR_CR_BLOCKS, cr);
      write_register(CSR_COLOUR_MODE, {pad, mode});
      csr_write_enable <= 1'b0;
      luma_cfg   = luma;
      cb_cfg     = cb;
      cr_cfg     = cr;
      colour_cfg = mode;
      @(posedge clock);
   endtask

   // track where an AC symbol leaves the zigzag position; true when it ends the block
   function automatic bit ac_step(logic [7:0] sym, inout int pos);
      int np;
      if (sym == SYM_EOB) return 1'b1;
      np = pos + int'(sym[7:4]) + 1;
      if (np > COEF_LAST) return 1'b1;
      pos = np;
      return (sym[3:0] != 4'd0) && (np == COEF_LAST);
   endfunction

   task automatic random_block(int eob_pct);
      logic [7:0] sym;
      int         pos;
      int         r;
      int         run;
      bit         noise;
      bit         ended;
      pos = 0;
      sym = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(16, 255))
                                        : 8'($urandom_range(0, 15));
      send_symbol(sym, 15'($urandom_range(0, 32767)));
      do begin
         r     = $urandom_range(0, 99);
         noise = 1'b0;
         if (r < eob_pct) begin
            sym = SYM_EOB;
         end else if (r < eob_pct + 5) begin
            sym = SYM_ZRL;
         end else if (r < eob_pct + 10) begin
            sym   = 8'($urandom_range(0, 255));
            noise = 1'b1;
         end else if (r < eob_pct + 14) begin
            sym = {4'($urandom_range(1, 14)), 4'h0};
         end else begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
            sym = {4'(run), 4'($urandom_range(1, 15))};
         end
         // mostly steer the run onto the last position instead of overflowing
         if (!noise && sym != SYM_EOB && pos + int'(sym[7:4]) + 1 > COEF_LAST
             && $urandom_range(0, 4) != 0) begin
            if (pos >= COEF_LAST) sym = SYM_EOB;
            else sym[7:4] = 4'(COEF_LAST - 1 - pos);
         end
         send_symbol(sym, 15'($urandom_range(0, 32767)));
         ended = ac_step(sym, pos);
      end while (!ended);
   endtask

   function automatic logic [4:0] pick_count();
      if ($urandom_range(0, 5) == 0) return 5'($urandom_range(0, 31));
      return 5'($urandom_range(1, 4));
   endfunction

   task automatic test_directed_symbols();
      // zero class DC, masked extra bits, ZRL, run with write, EOB
      send_symbol(8'h00, 15'h0000);
      send_symbol(8'h01, 15'h0001);
      send_symbol(8'h01, 15'h7FFE);
      send_symbol(SYM_ZRL, 15'h7FFF);
      send_symbol(8'h5A, 15'h03FF);
      send_symbol(SYM_EOB, 15'h7FFF);
      // most negative DC class, widest AC value, write on the last position
      send_symbol(8'h0F, 15'h0000);
      send_symbol(8'hFF, 15'h7FFF);
      send_symbol(SYM_ZRL, 15'h0000);
      send_symbol(SYM_ZRL, 15'h0000);
      send_symbol(8'hEF, 15'h0000);
      // DC symbol above class 15, skip landing on the last position, then EOB
      send_symbol(8'hFF, 15'h7FFF);
      send_symbol(SYM_ZRL, 15'h0000);
      send_symbol(SYM_ZRL, 15'h0000);
      send_symbol(SYM_ZRL, 15'h0000);
      send_symbol(8'hE0, 15'h0000);
      send_symbol(SYM_EOB, 15'h0000);
      // skip landing on the last position, then a run past it
      send_symbol(8'h10, 15'h1234);
      send_symbol(SYM_ZRL, 15'h0000);
      send_symbol(SYM_ZRL, 15'h0000);
      send_symbol(SYM_ZRL, 15'h0000);
      send_symbol(8'hE0, 15'h0000);
      send_symbol(8'h01, 15'h0001);
   endtask

   task automatic test_sampling_layouts();
      int layout [9][4] = '{
         '{1, 1, 1, 1}, '{4, 1, 1, 1}, '{2, 1, 1, 1}, '{16, 16, 16, 1}, '{0, 0, 0, 1},
         '{31, 17, 24, 1}, '{16, 5, 9, 0}, '{3, 2, 2, 1}, '{1, 1, 1, 0}
      };
      int total;
      for (int i = 0; i < 9; i++) begin
         apply_setting(5'(layout[i][0]), 5'(layout[i][1]), 5'(layout[i][2]),
                       1'(layout[i][3]));
         total = blocks_per_mcu();
         repeat (total + 2) random_block((total > 8) ? 50 : 12);
      end
   endtask

   task automatic test_mid_mcu_reconfig();
      apply_setting(5'd16, 5'd16, 5'd16, 1'b1);
      repeat (40) random_block(100);
      apply_setting(5'd2, 5'd1, 5'd1, 1'b1);
      repeat (3) random_block(100);
      apply_setting(5'd16, 5'd1, 5'd1, 1'b0);
      repeat (20) random_block(100);
      apply_setting(5'd3, 5'd1, 5'd1, 1'b0);
      repeat (3) random_block(30);
   endtask

   task automatic test_output_backpressure();
      apply_setting(5'd4, 5'd1, 5'd1, 1'b1);
      receiver_hold = HOLD_CYCLES;
      repeat (3) random_block(12);
      wait_for_idle();
   endtask

   task automatic test_sender_pause();
      random_block(12);
      send_symbol(8'($urandom_range(0, 15)), 15'($urandom_range(0, 32767)));
      wait_for_idle();
      send_symbol(8'h23, 15'($urandom_range(0, 32767)));
      send_symbol(SYM_EOB, 15'($urandom_range(0, 32767)));
      wait_for_idle();
      random_block(12);
   endtask

   task automatic test_random_stream();
      while (items_sent < ITEM_TARGET - 300) begin
         apply_setting(pick_count(), pick_count(), pick_count(), 1'($urandom_range(0, 1)));
         repeat (12) random_block(12);
      end
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      while (items_sent < ITEM_TARGET) random_block(12);
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.payload   = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_LUMA_BLOCKS;
      csr_data         = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_symbols();
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
      test_sampling_layouts();
      test_mid_mcu_reconfig();
      test_output_backpressure();
      test_sender_pause();
      test_random_stream();
      wait_for_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_coefs.size() == 0) begin
         $display("tb_jpeg_coefficient_run_length_decoder: clean");
      end else begin
         $display("tb_jpeg_coefficient_run_length_decoder: errors");
      end
      $finish;
   end

endmodule
